>>> rtl/wavetable_voice_mixer_top_defines.svh
// Assertion macros shared by the wavetable voice mixer RTL.
`ifndef WAVETABLE_VOICE_MIXER_TOP_DEFINES_SVH
`define WAVETABLE_VOICE_MIXER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define WVM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define WVM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/wvm_pkg.sv
// Shared constants and types for the wavetable voice mixer.
`timescale 1ns / 1ps
package wvm_pkg;

   localparam int VOICE_COUNT_DEF      = 16;
   localparam int SAMPLE_ADDR_BITS_DEF = 16;
   localparam int STEP_BITS_DEF        = 20;

   // Request modes
   localparam logic [1:0] MODE_SAMPLE_WRITE = 2'd0;
   localparam logic [1:0] MODE_VOICE_WRITE  = 2'd1;
   localparam logic [1:0] MODE_MIX          = 2'd2;

   // Voice field codes
   localparam logic [2:0] FIELD_START    = 3'd0;
   localparam logic [2:0] FIELD_LENGTH   = 3'd1;
   localparam logic [2:0] FIELD_LOOP     = 3'd2;
   localparam logic [2:0] FIELD_STEP     = 3'd3;
   localparam logic [2:0] FIELD_VOLUME   = 3'd4;
   localparam logic [2:0] FIELD_POSITION = 3'd5;
   localparam logic [2:0] FIELD_ENABLE   = 3'd6;

   localparam logic [5:0]  VOLUME_MAX  = 6'd63;
   localparam logic [16:0] POS_MAX     = 17'h1FFFF;
   localparam logic [7:0]  SAMPLE_ZERO = 8'h80;
   localparam logic [7:0]  OUT_MIN     = 8'h00;
   localparam logic [7:0]  OUT_MAX     = 8'hFF;
   localparam int          FRAC_BITS   = 16;
   localparam int          MIX_SHIFT   = 8;
   localparam int          PROD_BITS   = 15;

   typedef struct packed {
      logic clear;   // zero the accumulator at mix start
      logic issue;   // one voice enters the datapath this cycle
   } mix_ctl_type;

endpackage

>>> rtl/wvm_sample_ram.sv
// Byte-wide sample memory, one write port and one registered read port.
`timescale 1ns / 1ps
module wvm_sample_ram #(
   parameter int ADDR_BITS = 16
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [7:0]           wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [7:0]           rd_data
);

   logic [7:0] mem [2**ADDR_BITS];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/wvm_voice_file.sv
// Voice state registers: field writes from requests and phase write-back from the mixer.
`timescale 1ns / 1ps
module wvm_voice_file
   import wvm_pkg::*;
#(
   parameter int VOICE_COUNT      = VOICE_COUNT_DEF,
   parameter int SAMPLE_ADDR_BITS = SAMPLE_ADDR_BITS_DEF,
   parameter int STEP_BITS        = STEP_BITS_DEF,
   localparam int VI = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [VI-1:0]               wr_idx,
   input  logic [2:0]                  wr_field,
   input  logic [19:0]                 wr_value,
   input  logic                        wb_valid,
   input  logic [VI-1:0]               wb_idx,
   input  logic [16:0]                 wb_position,
   input  logic [15:0]                 wb_fraction,
   input  logic                        wb_enabled,
   input  logic [VI-1:0]               rd_idx,
   output logic [SAMPLE_ADDR_BITS-1:0] rd_start,
   output logic [15:0]                 rd_length,
   output logic [15:0]                 rd_loop,
   output logic [STEP_BITS-1:0]        rd_step,
   output logic [5:0]                  rd_volume,
   output logic [16:0]                 rd_position,
   output logic [15:0]                 rd_fraction,
   output logic                        rd_enabled
);

   logic [SAMPLE_ADDR_BITS-1:0] start_ff    [VOICE_COUNT];
   logic [15:0]                 length_ff   [VOICE_COUNT];
   logic [15:0]                 loop_ff     [VOICE_COUNT];
   logic [STEP_BITS-1:0]        step_ff     [VOICE_COUNT];
   logic [5:0]                  volume_ff   [VOICE_COUNT];
   logic [16:0]                 position_ff [VOICE_COUNT];
   logic [15:0]                 fraction_ff [VOICE_COUNT];
   logic [VOICE_COUNT-1:0]      enabled_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < VOICE_COUNT; i++) begin
            start_ff[i]    <= '0;
            length_ff[i]   <= '0;
            loop_ff[i]     <= '0;
            step_ff[i]     <= '0;
            volume_ff[i]   <= '0;
            position_ff[i] <= '0;
            fraction_ff[i] <= '0;
         end
         enabled_ff <= '0;
      end else if (wb_valid) begin
         position_ff[wb_idx] <= wb_position;
         fraction_ff[wb_idx] <= wb_fraction;
         enabled_ff[wb_idx]  <= wb_enabled;
      end else if (wr_en) begin
         unique case (wr_field)
            FIELD_START:    start_ff[wr_idx]    <= SAMPLE_ADDR_BITS'(wr_value);
            FIELD_LENGTH:   length_ff[wr_idx]   <= wr_value[15:0];
            FIELD_LOOP:     loop_ff[wr_idx]     <= wr_value[15:0];
            FIELD_STEP:     step_ff[wr_idx]     <= STEP_BITS'(wr_value);
            FIELD_VOLUME:   volume_ff[wr_idx]   <= (wr_value > 20'(VOLUME_MAX)) ?
                                                   VOLUME_MAX : wr_value[5:0];
            FIELD_POSITION: position_ff[wr_idx] <= wr_value[16:0];
            FIELD_ENABLE:   enabled_ff[wr_idx]  <= wr_value[0];
            default: ;
         endcase
      end
   end

   assign rd_start    = start_ff[rd_idx];
   assign rd_length   = length_ff[rd_idx];
   assign rd_loop     = loop_ff[rd_idx];
   assign rd_step     = step_ff[rd_idx];
   assign rd_volume   = volume_ff[rd_idx];
   assign rd_position = position_ff[rd_idx];
   assign rd_fraction = fraction_ff[rd_idx];
   assign rd_enabled  = enabled_ff[rd_idx];

endmodule

>>> rtl/wvm_mix_unit.sv
// Shared per-voice datapath: fetch, scale, phase advance, end check, accumulate, finalize.
`timescale 1ns / 1ps
module wvm_mix_unit
   import wvm_pkg::*;
#(
   parameter int VOICE_COUNT      = VOICE_COUNT_DEF,
   parameter int SAMPLE_ADDR_BITS = SAMPLE_ADDR_BITS_DEF,
   parameter int STEP_BITS        = STEP_BITS_DEF,
   localparam int VI = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  mix_ctl_type                 ctl,
   input  logic [VI-1:0]               issue_idx,
   input  logic [SAMPLE_ADDR_BITS-1:0] v_start,
   input  logic [15:0]                 v_length,
   input  logic [15:0]                 v_loop,
   input  logic [STEP_BITS-1:0]        v_step,
   input  logic [5:0]                  v_volume,
   input  logic [16:0]                 v_position,
   input  logic [15:0]                 v_fraction,
   input  logic                        v_enabled,
   output logic [SAMPLE_ADDR_BITS-1:0] ram_rd_addr,
   input  logic [7:0]                  ram_rd_data,
   output logic                        wb_valid,
   output logic [VI-1:0]               wb_idx,
   output logic [16:0]                 wb_position,
   output logic [15:0]                 wb_fraction,
   output logic                        wb_enabled,
   output logic                        pipe_busy,
   output logic [7:0]                  mix_sample
);

   localparam int SUM_BITS = PROD_BITS + $clog2(VOICE_COUNT) + 1;
   localparam logic signed [SUM_BITS:0] HALF_LSB  = (SUM_BITS+1)'(SAMPLE_ZERO);
   localparam logic signed [SUM_BITS:0] OUT_BIAS  = (SUM_BITS+1)'(SAMPLE_ZERO);
   localparam logic signed [SUM_BITS:0] CLAMP_HI  = (SUM_BITS+1)'(OUT_MAX);

   // Stage 1: fetch issued, fraction advanced
   logic                 s1_valid_ff;
   logic [VI-1:0]        s1_idx_ff;
   logic                 s1_en_ff;
   logic [5:0]           s1_vol_ff;
   logic [16:0]          s1_pos_ff;
   logic [STEP_BITS:0]   s1_acc_ff;
   logic [15:0]          s1_length_ff;
   logic [15:0]          s1_loop_ff;

   // Stage 2: product and advanced position
   logic                        s2_valid_ff;
   logic [VI-1:0]               s2_idx_ff;
   logic                        s2_en_ff;
   logic [16:0]                 s2_pos_ff;
   logic [15:0]                 s2_frac_ff;
   logic [15:0]                 s2_length_ff;
   logic [15:0]                 s2_loop_ff;
   logic signed [PROD_BITS-1:0] s2_prod_ff;

   logic signed [SUM_BITS-1:0] sum_ff;

   logic [STEP_BITS:0]          acc_in;
   logic [17:0]                 pos_sum;
   logic [16:0]                 pos_adv;
   logic signed [6:0]           vol_s;
   logic signed [7:0]           smp_s;
   logic signed [PROD_BITS-1:0] prod_raw;
   logic signed [PROD_BITS-1:0] prod_in;
   logic                        at_end;
   logic [16:0]                 pos_wrap;
   logic signed [SUM_BITS:0]    rnd;
   logic signed [SUM_BITS:0]    shf;
   logic signed [SUM_BITS:0]    base;

   // Stage 0: address the sample and add the step to the fraction
   assign ram_rd_addr = v_start + SAMPLE_ADDR_BITS'(v_position);
   assign acc_in      = (STEP_BITS+1)'(v_fraction) + (STEP_BITS+1)'(v_step);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= ctl.issue;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff    <= issue_idx;
      s1_en_ff     <= v_enabled;
      s1_vol_ff    <= v_volume;
      s1_pos_ff    <= v_position;
      s1_acc_ff    <= acc_in;
      s1_length_ff <= v_length;
      s1_loop_ff   <= v_loop;
   end

   // Stage 1: carry into position (saturating) and scale the sample
   assign pos_sum  = {1'b0, s1_pos_ff} + 18'(s1_acc_ff[STEP_BITS:FRAC_BITS]);
   assign pos_adv  = pos_sum[17] ? POS_MAX : pos_sum[16:0];
   assign vol_s    = $signed({1'b0, s1_vol_ff});
   assign smp_s    = $signed({~ram_rd_data[7], ram_rd_data[6:0]});
   // Keep the multiply in a signed context of its own
   assign prod_raw = vol_s * smp_s;
   assign prod_in  = s1_en_ff ? prod_raw : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_idx_ff    <= s1_idx_ff;
      s2_en_ff     <= s1_en_ff;
      s2_pos_ff    <= pos_adv;
      s2_frac_ff   <= s1_acc_ff[FRAC_BITS-1:0];
      s2_length_ff <= s1_length_ff;
      s2_loop_ff   <= s1_loop_ff;
      s2_prod_ff   <= prod_in;
   end

   // Stage 2: end of sample, loop or stop, then write back
   assign at_end   = s2_pos_ff >= 17'(s2_length_ff);
   assign pos_wrap = (17'(s2_loop_ff) > s2_pos_ff) ? '0 : s2_pos_ff - 17'(s2_loop_ff);

   always_comb begin
      wb_position = s2_pos_ff;
      wb_enabled  = 1'b1;
      if (at_end) begin
         if (s2_loop_ff == '0) begin
            wb_enabled = 1'b0;
         end else begin
            wb_position = pos_wrap;
         end
      end
   end

   assign wb_valid    = s2_valid_ff & s2_en_ff;
   assign wb_idx      = s2_idx_ff;
   assign wb_fraction = s2_frac_ff;
   assign pipe_busy   = s1_valid_ff | s2_valid_ff;

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         sum_ff <= '0;
      end else if (s2_valid_ff) begin
         sum_ff <= sum_ff + SUM_BITS'(s2_prod_ff);
      end
   end

   // Round to nearest, floor-shift, recenter and clamp
   always_comb begin
      rnd = $signed({sum_ff[SUM_BITS-1], sum_ff}) + HALF_LSB;
      shf = rnd >>> MIX_SHIFT;
      base = shf + OUT_BIAS;
      if (base[SUM_BITS]) begin
         mix_sample = OUT_MIN;
      end else if (base > CLAMP_HI) begin
         mix_sample = OUT_MAX;
      end else begin
         mix_sample = base[7:0];
      end
   end

endmodule

>>> rtl/wavetable_voice_mixer_top.sv
// Top level of the wavetable voice mixer: request decode, voice sequencer and result register.
//
// Usage:
//   The request channel (req_*) carries one transaction per accepted item: a sample
//   byte write, a voice field write, or a mix request. Writes return nothing; after
//   a write the block takes the next transaction in the following cycle.
//   A mix request walks the voices one per cycle through a three-stage shared
//   datapath, then rounds and clamps the sum into the result register that drives
//   rsp_output_sample. req_stall stays high through the walk and the drain, until
//   the result register loads, as the single voice pipeline and the single sample
//   memory read port are busy with the walk.
//   The csr_* port writes the signed-output bit; write it only while
//   no transaction is in flight.
//   A result waiting under rsp_stall does not block writes. A following mix runs
//   its walk and then holds in the drain state until the result register frees.
//   Reset (synchronous, active high) disables every voice, zeroes the voice fields
//   and the signed-output bit, and drops any pending result. The sample memory is
//   not cleared; read only bytes that were written.
`timescale 1ns / 1ps
`include "wavetable_voice_mixer_top_defines.svh"
module wavetable_voice_mixer_top
   import wvm_pkg::*;
#(
   parameter int VOICE_COUNT      = VOICE_COUNT_DEF,
   parameter int SAMPLE_ADDR_BITS = SAMPLE_ADDR_BITS_DEF,
   parameter int STEP_BITS        = STEP_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_sample_byte,
   input  logic [3:0]  req_voice,
   input  logic [2:0]  req_voice_field,
   input  logic [19:0] req_field_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_output_sample,
   input  logic        csr_write_en,
   input  logic        csr_write_data
);

   localparam int VI = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
   localparam logic [VI-1:0] LAST_VOICE = VI'(VOICE_COUNT - 1);

   // Sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [VI-1:0] cnt_ff, cnt_in;
   logic          signed_output_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_sample_ff;

   mix_ctl_type mix_ctl;
   logic        req_accept;
   logic        out_free;
   logic        load_out;
   logic        voice_wr_en;
   logic        ram_wr_en;

   logic [SAMPLE_ADDR_BITS-1:0] v_start;
   logic [15:0]                 v_length;
   logic [15:0]                 v_loop;
   logic [STEP_BITS-1:0]        v_step;
   logic [5:0]                  v_volume;
   logic [16:0]                 v_position;
   logic [15:0]                 v_fraction;
   logic                        v_enabled;
   logic [SAMPLE_ADDR_BITS-1:0] ram_rd_addr;
   logic [7:0]                  ram_rd_data;
   logic                        wb_valid;
   logic [VI-1:0]               wb_idx;
   logic [16:0]                 wb_position;
   logic [15:0]                 wb_fraction;
   logic                        wb_enabled;
   logic                        pipe_busy;
   logic [7:0]                  mix_sample;

   // Take transactions only between mixes
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid & ~req_stall;
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;

   // Writes land the same cycle; an out-of-range voice index drops the write
   assign ram_wr_en   = req_accept && (req_mode == MODE_SAMPLE_WRITE);
   assign voice_wr_en = req_accept && (req_mode == MODE_VOICE_WRITE) &&
                        (32'(req_voice) < 32'(VOICE_COUNT));

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      mix_ctl  = '0;
      load_out = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_mode == MODE_MIX)) begin
               mix_ctl.clear = 1'b1;
               cnt_in        = '0;
               state_in      = ST_RUN;
            end
         end
         ST_RUN: begin
            // Issue one voice per cycle
            mix_ctl.issue = 1'b1;
            if (cnt_ff == LAST_VOICE) begin
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + VI'(1);
            end
         end
         ST_DRAIN: begin
            // Hold until the last voice is summed and the result register is free
            if (!pipe_busy && out_free) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         cnt_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
         signed_output_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            signed_output_ff <= csr_write_data;
         end
      end
   end

   // Flip bit 7 for signed output
   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_sample_ff <= mix_sample ^ (SAMPLE_ZERO & {8{signed_output_ff}});
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_output_sample = rsp_sample_ff;

   wvm_sample_ram #(
      .ADDR_BITS (SAMPLE_ADDR_BITS)
   ) u_sample_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (SAMPLE_ADDR_BITS'(req_address)),
      .wr_data (req_sample_byte),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   wvm_voice_file #(
      .VOICE_COUNT      (VOICE_COUNT),
      .SAMPLE_ADDR_BITS (SAMPLE_ADDR_BITS),
      .STEP_BITS        (STEP_BITS)
   ) u_voice_file (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (voice_wr_en),
      .wr_idx      (VI'(req_voice)),
      .wr_field    (req_voice_field),
      .wr_value    (req_field_value),
      .wb_valid    (wb_valid),
      .wb_idx      (wb_idx),
      .wb_position (wb_position),
      .wb_fraction (wb_fraction),
      .wb_enabled  (wb_enabled),
      .rd_idx      (cnt_ff),
      .rd_start    (v_start),
      .rd_length   (v_length),
      .rd_loop     (v_loop),
      .rd_step     (v_step),
      .rd_volume   (v_volume),
      .rd_position (v_position),
      .rd_fraction (v_fraction),
      .rd_enabled  (v_enabled)
   );

   wvm_mix_unit #(
      .VOICE_COUNT      (VOICE_COUNT),
      .SAMPLE_ADDR_BITS (SAMPLE_ADDR_BITS),
      .STEP_BITS        (STEP_BITS)
   ) u_mix_unit (
      .clock       (clock),
      .reset       (reset),
      .ctl         (mix_ctl),
      .issue_idx   (cnt_ff),
      .v_start     (v_start),
      .v_length    (v_length),
      .v_loop      (v_loop),
      .v_step      (v_step),
      .v_volume    (v_volume),
      .v_position  (v_position),
      .v_fraction  (v_fraction),
      .v_enabled   (v_enabled),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .wb_valid    (wb_valid),
      .wb_idx      (wb_idx),
      .wb_position (wb_position),
      .wb_fraction (wb_fraction),
      .wb_enabled  (wb_enabled),
      .pipe_busy   (pipe_busy),
      .mix_sample  (mix_sample)
   );

   // A mix transaction always starts the voice walk
   `WVM_ASSERT_NEXT(a_mix_starts_walk, clock, reset, req_accept && (req_mode == MODE_MIX), state_ff == ST_RUN, "mix accepted without starting the voice walk")
   // No voice write-back outside a mix
   `WVM_ASSERT_NOW(a_no_wb_when_idle, clock, reset, state_ff == ST_IDLE, !wb_valid, "voice write-back while idle")
   // The pipeline empties only while draining
   `WVM_ASSERT_NOW(a_drain_empties_pipe, clock, reset, $fell(pipe_busy) && !$past(reset), state_ff == ST_DRAIN, "datapath emptied outside drain")

endmodule

>>> tb/wavetable_voice_mixer_top_tb.sv
// Self-checking testbench for the wavetable voice mixer: directed table, random scenes, predictor.
`timescale 1ns / 1ps
module wavetable_voice_mixer_top_tb;
   import wvm_pkg::*;

   localparam int VOICES       = VOICE_COUNT_DEF;
   localparam int ITEM_TARGET  = 1400;
   localparam int PHASES       = 4;
   // One mix walks every voice plus three pipeline stages; leave some margin.
   localparam int DRAIN_CYCLES = VOICE_COUNT_DEF + 8;
   localparam int QUIET_LIMIT  = 2000;
   localparam int REPORT_LIMIT = 10;

   // Codes the block ignores: the fourth request mode and the eighth field code.
   localparam logic [1:0] MODE_RESERVED  = 2'd3;
   localparam logic [2:0] FIELD_RESERVED = 3'd7;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] address;
      logic [7:0]  sample_byte;
      logic [3:0]  voice;
      logic [2:0]  field;
      logic [19:0] value;
   } req_item_type;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      req_item_type req;          // for a CSR row, value bit 0 is the register data
      logic         typed;        // expected sample given below instead of predicted
      logic [7:0]   typed_sample;
   } dir_row_type;

   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_HOLD, STALL_TOGGLE} stall_style_type;

   // Directed table: edges of the start, volume, step, position and loop fields, every
   // field code but the length, both ignored codes, zero length, position saturation,
   // loop wrap, loop longer than position, and the signed-output flip.
   localparam dir_row_type DIRECTED_ROWS [0:26] = '{
      // nothing enabled after reset: the mix sits at the zero level
      '{ROW_REQ, '{MODE_MIX,          16'h0000, 8'h00, 4'd0,  FIELD_START,    20'h00000},
        1'b1, 8'h80},
      '{ROW_REQ, '{MODE_SAMPLE_WRITE, 16'hFFFF, 8'hFF, 4'd0,  FIELD_START,    20'h00000},
        1'b0, 8'h00},
      '{ROW_REQ, '{MODE_SAMPLE_WRITE, 16'h0000, 8'h00, 4'd0,  FIELD_START,    20'h00000},
        1'b0, 8'h00},
      '{ROW_REQ, '{MODE_SAMPLE_WRITE, 16'hFFFE, 8'h7F, 4'd0,  FIELD_START,    20'h00000},
        1'b0, 8'h00},
      // wide start truncates, wide volume saturates
      '{ROW_REQ, '{MODE_VOICE_WRITE,  16'h0000, 8'h00, 4'd0,  FIELD_START,    20'hFFFFF},
        1'b0, 8'h00},
      '{ROW_REQ, '{MODE_VOICE_WRITE,  16'h0000, 8'h00, 4'd0,  FIELD_VOLUME,   20'hFFFFF},
        1'b0, 8'h00},
      '{ROW_REQ, '{MODE_VOICE_WRITE,  16'h0000, 8'h00, 4'd0,  FIELD_STEP,     20'h10000},
        1'b0, 8'h00},
      '{ROW_REQ, '{MODE_VOICE_WRITE,  16'h0000, 8'h00, 4'd0,  FIELD_ENABLE,   20'h00001},
        1'b0, 8'h00},
      // zero length, zero loop: one sample, then the voice ends
      '{ROW_REQ, '{MODE_MIX,          16'h0000, 8'h00, 4'd0,  FIELD_START,    20'h00000},
        1'b0, 8'h00},
      '{ROW_REQ, '{MODE_MIX,          16'h0000, 8'h00, 4'd0,  FIELD_START,    20'h00000},
        1'b1, 8'h80},
      // top position and top step: the advance saturates, then the loop pulls back
      '{ROW_REQ, '{MODE_VOICE_WRITE,  16'h0000, 8'h00, 4'd0,  FIELD_POSITION, 20'hFFFFF},
        1'b0, 8'h00},
      '{ROW_REQ, '{MODE_VOICE_WRITE,  16'h0000, 8'h00, 4'd0,  FIELD_STEP,     20'hFFFFF},
        1'b0, 8'h00},
      '{ROW_REQ, '{MODE_VOICE_WRITE,  16'h0000, 8'h00, 4'd0,  FIELD_LOOP,     20'hFFFFF},
        1'b0, 8'h00},
      '{ROW_REQ, '{MODE_VOICE_WRITE,  16'h0000, 8'h00, 4'd0,  FIELD_ENABLE,   20'hFFFFF},
        1'b0, 8'h00},
      // last voice: loop longer than position snaps it back to zero
      '{ROW_REQ, '{MODE_VOICE_WRITE,  16'h0000, 8'h00, 4'd15, FIELD_VOLUME,   20'h0003F},
        1'b0, 8'h00},
      '{ROW_REQ, '{MODE_VOICE_WRITE,  16'h0000, 8'h00, 4'd15, FIELD_LOOP,     20'h0FFFF},
        1'b0, 8'h00},
      '{ROW_REQ, '{MODE_VOICE_WRITE,  16'h0000, 8'h00, 4'd15, FIELD_ENABLE,   20'h00001},
        1'b0, 8'h00},
      '{ROW_REQ, '{MODE_MIX,          16'h0000, 8'h00, 4'd0,  FIELD_START,    20'h00000},
        1'b0, 8'h00},
      '{ROW_REQ, '{MODE_MIX,          16'h0000, 8'h00, 4'd0,  FIELD_START,    20'h00000},
        1'b0, 8'h00},
      // ignored mode and ignored field code
      '{ROW_REQ, '{MODE_RESERVED,     16'hFFFF, 8'hFF, 4'd15, FIELD_RESERVED, 20'hFFFFF},
        1'b0, 8'h00},
      '{ROW_REQ, '{MODE_VOICE_WRITE,  16'hFFFF, 8'hFF, 4'd15, FIELD_RESERVED, 20'hFFFFF},
        1'b0, 8'h00},
      '{ROW_CSR, '{MODE_MIX,          16'h0000, 8'h00, 4'd0,  FIELD_START,    20'h00001},
        1'b0, 8'h00},
      '{ROW_REQ, '{MODE_MIX,          16'h0000, 8'h00, 4'd0,  FIELD_START,    20'h00000},
        1'b0, 8'h00},
      '{ROW_REQ, '{MODE_VOICE_WRITE,  16'h0000, 8'h00, 4'd0,  FIELD_ENABLE,   20'h00000},
        1'b0, 8'h00},
      '{ROW_REQ, '{MODE_VOICE_WRITE,  16'h0000, 8'h00, 4'd15, FIELD_ENABLE,   20'h00000},
        1'b0, 8'h00},
      // silent mix with the top bit flipped
      '{ROW_REQ, '{MODE_MIX,          16'h0000, 8'h00, 4'd0,  FIELD_START,    20'h00000},
        1'b1, 8'h00},
      '{ROW_CSR, '{MODE_MIX,          16'h0000, 8'h00, 4'd0,  FIELD_START,    20'h00000},
        1'b0, 8'h00}
   };

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_mode;
   logic [15:0] req_address;
   logic [7:0]  req_sample_byte;
   logic [3:0]  req_voice;
   logic [2:0]  req_voice_field;
   logic [19:0] req_field_value;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_output_sample;
   logic        csr_write_en;
   logic        csr_write_data;

   wavetable_voice_mixer_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_address       (req_address),
      .req_sample_byte   (req_sample_byte),
      .req_voice         (req_voice),
      .req_voice_field   (req_voice_field),
      .req_field_value   (req_field_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_output_sample (rsp_output_sample),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Predicted copy of the block's state. All-zero start matches reset; the
   // written map keeps every mix away from sample bytes nobody has stored.
   bit [7:0]  sample_mem     [65536];
   bit        sample_written [65536];
   bit [15:0] voice_start    [VOICES];
   bit [15:0] voice_length   [VOICES];
   bit [15:0] voice_loop     [VOICES];
   bit [19:0] voice_step     [VOICES];
   bit [5:0]  voice_volume   [VOICES];
   bit [16:0] voice_pos      [VOICES];
   bit [15:0] voice_frac     [VOICES];
   bit        voice_on       [VOICES];
   bit        signed_output;

   logic [7:0] pending_samples [$];

   int burst_left      = 0;
   int requests_sent   = 0;
   int samples_checked = 0;
   int csr_writes      = 0;
   int error_count     = 0;

   function automatic void note_failure(input string msg);
      if (error_count < REPORT_LIMIT)
         $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endfunction

   // Apply one accepted transaction to the predicted state; a mix yields a sample.
   function automatic void apply_request(input req_item_type r, output logic produced,
                                         output logic [7:0] out_sample);
      int         mix_sum;
      int         rounded;
      logic [20:0] frac_sum;
      logic [17:0] next_pos;
      logic [16:0] pos;
      logic [15:0] read_addr;
      produced   = 1'b0;
      out_sample = '0;
      case (r.mode)
         MODE_SAMPLE_WRITE: begin
            sample_mem[r.address]     = r.sample_byte;
            sample_written[r.address] = 1'b1;
         end
         MODE_VOICE_WRITE: begin
            if (int'(r.voice) < VOICES) begin
               case (r.field)
                  FIELD_START:    voice_start[r.voice]  = r.value[15:0];
                  FIELD_LENGTH:   voice_length[r.voice] = r.value[15:0];
                  FIELD_LOOP:     voice_loop[r.voice]   = r.value[15:0];
                  FIELD_STEP:     voice_step[r.voice]   = r.value;
                  FIELD_VOLUME:   voice_volume[r.voice] =
                     (r.value > 20'(VOLUME_MAX)) ? VOLUME_MAX : r.value[5:0];
                  FIELD_POSITION: voice_pos[r.voice]    = r.value[16:0];
                  FIELD_ENABLE:   voice_on[r.voice]     = r.value[0];
                  default: ;
               endcase
            end
         end
         MODE_MIX: begin
            mix_sum = 0;
            for (int v = 0; v < VOICES; v++) begin
               if (voice_on[v]) begin
                  read_addr = voice_start[v] + voice_pos[v][15:0];
                  mix_sum += int'(voice_volume[v]) *
                             (int'(sample_mem[read_addr]) - int'(SAMPLE_ZERO));
                  // advance the phase, saturate, then handle the end of the sample
                  frac_sum = {5'b0, voice_frac[v]} + {1'b0, voice_step[v]};
                  next_pos = {1'b0, voice_pos[v]} + 18'(frac_sum[20:FRAC_BITS]);
                  if (next_pos > {1'b0, POS_MAX})
                     next_pos = {1'b0, POS_MAX};
                  voice_frac[v] = frac_sum[15:0];
                  pos = next_pos[16:0];
                  if (pos >= {1'b0, voice_length[v]}) begin
                     if (voice_loop[v] == 16'd0)
                        voice_on[v] = 1'b0;
                     else if ({1'b0, voice_loop[v]} > pos)
                        pos = '0;
                     else
                        pos = pos - {1'b0, voice_loop[v]};
                  end
                  voice_pos[v] = pos;
               end
            end
            rounded = ((mix_sum + (1 << (MIX_SHIFT - 1))) >>> MIX_SHIFT) + int'(SAMPLE_ZERO);
            if (rounded < int'(OUT_MIN))
               out_sample = OUT_MIN;
            else if (rounded > int'(OUT_MAX))
               out_sample = OUT_MAX;
            else
               out_sample = rounded[7:0];
            if (signed_output)
               out_sample = out_sample ^ SAMPLE_ZERO;
            produced = 1'b1;
         end
         default: ;
      endcase
   endfunction

   // First enabled voice whose next read lands on a byte never stored.
   function automatic logic find_unwritten_read(output logic [15:0] hole);
      hole = '0;
      for (int v = 0; v < VOICES; v++) begin
         if (voice_on[v] && !sample_written[16'(voice_start[v] + voice_pos[v][15:0])]) begin
            hole = voice_start[v] + voice_pos[v][15:0];
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic req_item_type random_req();
      req_item_type r;
      r.mode        = 2'($urandom_range(MODE_SAMPLE_WRITE, MODE_RESERVED));
      r.address     = 16'($urandom);
      r.sample_byte = 8'($urandom);
      r.voice       = 4'($urandom);
      r.field       = 3'($urandom_range(FIELD_START, FIELD_RESERVED));
      r.value       = 20'($urandom);
      return r;
   endfunction

   // Drive one transaction at the falling edge, hold it until accepted, then
   // update the prediction. Bursts end in a gap with req_valid low.
   task automatic send_item(input req_item_type r, input logic use_typed,
                            input logic [7:0] typed_sample);
      logic       produced;
      logic [7:0] predicted;
      @(negedge clock);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      req_valid       <= 1'b1;
      req_mode        <= r.mode;
      req_address     <= r.address;
      req_sample_byte <= r.sample_byte;
      req_voice       <= r.voice;
      req_voice_field <= r.field;
      req_field_value <= r.value;
      do
         @(posedge clock);
      while (req_stall);
      burst_left--;
      apply_request(r, produced, predicted);
      if (produced)
         pending_samples.push_back(use_typed ? typed_sample : predicted);
      if (r.mode != MODE_RESERVED &&
          !(r.mode == MODE_VOICE_WRITE && r.field == FIELD_RESERVED))
         requests_sent++;
   endtask

   // Before a mix, store a random byte under every read that would hit empty memory.
   task automatic send_request(input req_item_type r, input logic use_typed,
                               input logic [7:0] typed_sample);
      logic [15:0]  hole;
      req_item_type fill;
      if (r.mode == MODE_MIX) begin
         while (find_unwritten_read(hole)) begin
            fill             = r;
            fill.mode        = MODE_SAMPLE_WRITE;
            fill.address     = hole;
            fill.sample_byte = 8'($urandom);
            send_item(fill, 1'b0, 8'h00);
         end
      end
      send_item(r, use_typed, typed_sample);
   endtask

   task automatic write_field(input int v, input logic [2:0] f, input logic [19:0] val);
      req_item_type r;
      r       = random_req();
      r.mode  = MODE_VOICE_WRITE;
      r.voice = 4'(v);
      r.field = f;
      r.value = val;
      send_item(r, 1'b0, 8'h00);
   endtask

   task automatic write_byte(input logic [15:0] addr, input logic [7:0] data);
      req_item_type r;
      r             = random_req();
      r.mode        = MODE_SAMPLE_WRITE;
      r.address     = addr;
      r.sample_byte = data;
      send_item(r, 1'b0, 8'h00);
   endtask

   // Drop valid, wait out every pending sample, then let the voice walk finish.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_samples.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_signed_output(input logic data);
      wait_idle();
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_en  <= 1'b0;
      signed_output = data;
      csr_writes++;
   endtask

   // One scene: set up a few voices over freshly written bytes, then mix a run
   // of samples. A loud scene drives all voices at full volume into the clamp.
   task automatic play_scene();
      int           voice_count;
      int           voice_sel;
      int           len;
      int           loop_len;
      int           fill_count;
      logic         loud;
      logic [15:0]  base;
      logic [7:0]   loud_byte;
      req_item_type mix;
      loud        = ($urandom_range(0, 4) == 0);
      voice_count = loud ? VOICES : $urandom_range(1, 6);
      base        = 16'($urandom);
      loud_byte   = $urandom_range(0, 1) ? OUT_MAX : OUT_MIN;
      if (loud) begin
         for (int i = 0; i < VOICES; i++)
            write_byte(base + 16'(i), loud_byte);
      end
      for (int k = 0; k < voice_count; k++) begin
         if (loud) begin
            write_field(k, FIELD_START,    {4'($urandom), base});
            write_field(k, FIELD_LENGTH,   20'(VOICES));
            write_field(k, FIELD_LOOP,     20'(VOICES));
            write_field(k, FIELD_STEP,     20'($urandom_range(1, 1 << FRAC_BITS)));
            write_field(k, FIELD_VOLUME,   20'(VOLUME_MAX));
            write_field(k, FIELD_POSITION, 20'h00000);
            write_field(k, FIELD_ENABLE,   {19'($urandom), 1'b1});
         end else begin
            voice_sel = $urandom_range(0, VOICES - 1);
            base      = 16'($urandom);
            case ($urandom_range(0, 7))
               0:       len = 0;
               1:       len = $urandom_range(0, 65535);
               default: len = $urandom_range(1, 48);
            endcase
            case ($urandom_range(0, 3))
               0:       loop_len = 0;
               1:       loop_len = len + $urandom_range(1, 64);
               default: loop_len = $urandom_range(1, (len > 0) ? len : 1);
            endcase
            fill_count = $urandom_range(1, 8);
            for (int i = 0; i < fill_count; i++)
               write_byte(base + 16'(i), 8'($urandom));
            write_field(voice_sel, FIELD_START,  {4'($urandom), base});
            write_field(voice_sel, FIELD_LENGTH, {4'($urandom), 16'(len)});
            write_field(voice_sel, FIELD_LOOP,   {4'($urandom), 16'(loop_len)});
            write_field(voice_sel, FIELD_STEP, ($urandom_range(0, 5) == 0) ?
                        20'($urandom) : 20'($urandom_range(0, 20'h30000)));
            write_field(voice_sel, FIELD_VOLUME, ($urandom_range(0, 3) == 0) ?
                        20'($urandom) : 20'($urandom_range(0, VOLUME_MAX)));
            if ($urandom_range(0, 3) != 0)
               write_field(voice_sel, FIELD_POSITION, ($urandom_range(0, 5) == 0) ?
                           20'($urandom) : 20'($urandom_range(0, len)));
            write_field(voice_sel, FIELD_ENABLE, {19'($urandom), 1'b1});
         end
      end
      repeat ($urandom_range(2, 20)) begin
         // now and then retune a voice in the middle of playback
         if ($urandom_range(0, 7) == 0)
            write_field($urandom_range(0, VOICES - 1),
                        3'($urandom_range(FIELD_START, FIELD_ENABLE)), 20'($urandom));
         mix      = random_req();
         mix.mode = MODE_MIX;
         send_request(mix, 1'b0, 8'h00);
      end
   endtask

   // Receiver: stretches of no stall, random stall, long holds and toggling.
   initial begin : rsp_stall_pattern
      stall_style_type style;
      rsp_stall = 1'b0;
      forever begin
         style = stall_style_type'($urandom_range(STALL_NONE, STALL_TOGGLE));
         repeat ($urandom_range(4, 40)) begin
            @(negedge clock);
            case (style)
               STALL_NONE:   rsp_stall <= 1'b0;
               STALL_RANDOM: rsp_stall <= ($urandom_range(0, 1) == 1);
               STALL_HOLD:   rsp_stall <= 1'b1;
               STALL_TOGGLE: rsp_stall <= !rsp_stall;
               default:      rsp_stall <= 1'b0;
            endcase
         end
      end
   end

   // Compare each accepted output sample with the oldest prediction.
   always @(posedge clock) begin : check_samples
      logic [7:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_samples.size() == 0) begin
            note_failure($sformatf("output sample %02h with nothing pending",
                                   rsp_output_sample));
         end else begin
            want = pending_samples.pop_front();
            samples_checked++;
            if (rsp_output_sample !== want)
               note_failure($sformatf("output_sample mismatch: expected %02h got %02h",
                                      want, rsp_output_sample));
         end
      end
   end

   // Watchdog: end the run if neither channel moves a transaction for too long.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      int           random_base;
      req_item_type noise;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_mode        = MODE_SAMPLE_WRITE;
      req_address     = '0;
      req_sample_byte = '0;
      req_voice       = '0;
      req_voice_field = FIELD_START;
      req_field_value = '0;
      csr_write_en    = 1'b0;
      csr_write_data  = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_signed_output(1'b0);

      // Directed part: walk the table in order.
      foreach (DIRECTED_ROWS[i]) begin
         if (DIRECTED_ROWS[i].kind == ROW_CSR)
            write_signed_output(DIRECTED_ROWS[i].req.value[0]);
         else
            send_request(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].typed,
                         DIRECTED_ROWS[i].typed_sample);
      end

      // Random part: alternate the output format between phases.
      random_base = requests_sent;
      for (int phase = 0; phase < PHASES; phase++) begin
         write_signed_output(phase % 2 == 0);
         while (requests_sent < random_base + (phase + 1) * ITEM_TARGET / PHASES) begin
            play_scene();
            // a little noise between scenes, ignored codes included
            repeat ($urandom_range(0, 6)) begin
               noise = random_req();
               send_request(noise, 1'b0, 8'h00);
            end
         end
      end

      wait_idle();
      while (pending_samples.size() != 0)
         note_failure($sformatf("output sample %02h never arrived",
                                pending_samples.pop_front()));
      $display("Covered %0d requests and %0d checked output samples,",
               requests_sent, samples_checked);
      $display("with %0d signed-output writes.", csr_writes);
      $display("Failures: %0d", error_count);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/wvm_pkg.sv
rtl/wvm_sample_ram.sv
rtl/wvm_voice_file.sv
rtl/wvm_mix_unit.sv
rtl/wavetable_voice_mixer_top.sv
tb/wavetable_voice_mixer_top_tb.sv
